@@ hw/rtl/rcdc_pkg.sv @@
// ---------------------------------------------------------------------------
// rcdc_pkg
// Shared types and constants of the content-defined chunker.
// ---------------------------------------------------------------------------
package rcdc_pkg;

  localparam int OFFSET_BITS  = 48;
  localparam int LENGTH_BITS  = 24;
  localparam int HASH_BITS    = 32;
  localparam int CFG_IDX_BITS = 4;
  localparam int CFG_DATA_BITS = 32;
  localparam int TBL_ADDR_BITS = 8;

  // Input word layout: byte_value, table_index, table_word.
  localparam int IN_DATA_BITS  = 48;
  // Output word layout: chunk_offset, chunk_length.
  localparam int OUT_DATA_BITS = 72;

  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_TABLE = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HASH_MULT = 4'd0,
    REG_HASH_MASK = 4'd1,
    REG_MIN_CHUNK = 4'd2,
    REG_MAX_CHUNK = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                   run_end;
    logic                   final_chunk;
    logic [LENGTH_BITS-1:0] len;
    logic [OFFSET_BITS-1:0] off;
  } chunk_res_t;

  // Up to two results leave the core per byte.
  typedef struct packed {
    logic [1:0] cnt;
    chunk_res_t e0;
    chunk_res_t e1;
  } res_push_t;

endpackage

@@ hw/rtl/rabin_content_defined_chunker.sv @@
// ---------------------------------------------------------------------------
// rabin_content_defined_chunker
// Splits a byte stream into content-defined chunks with a running hash.
// ---------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  in_      in   in_tvalid/in_tready   tdata byte/index/word, tuser kind, tlast eos
//  out_     out  out_tvalid/out_tready tdata offset/length, tuser run end, tlast final
//  cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One byte is accepted every cycle while the result queue has room; the table
// read is registered and the multiply-add of the hash closes when that byte is
// passed on to the result queue. A byte that both cuts and ends the stream
// yields two results.
// Reset is synchronous; the byte table is not cleared and must be loaded.
// When the output stalls, the four-entry result queue fills, and in_tready
// drops once it holds more than two entries while a byte waits for the hash.
module rabin_content_defined_chunker
  import rcdc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // byte_value, table_index, table_word
  input  logic                     in_tuser,   // req_type
  input  logic                     in_tlast,   // end_of_stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // chunk_offset, chunk_length
  output logic                     out_tuser,  // run_end
  output logic                     out_tlast,  // final_chunk
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic           accept, byte_load, tbl_write;
  logic           take_ok, q_room;
  logic [HASH_BITS-1:0] tbl_word;
  res_push_t      push;
  chunk_res_t     head;

  assign cfg_ready = 1'b1;
  assign in_tready = take_ok;
  assign accept    = in_tvalid && in_tready;
  assign byte_load = accept && (in_tuser == REQ_DATA);
  assign tbl_write = accept && (in_tuser == REQ_TABLE);

  rcdc_table u_table (
    .clk     (clk),
    .wr_en   (tbl_write),
    .wr_addr (in_tdata[15:8]),
    .wr_data (in_tdata[47:16]),
    .rd_en   (byte_load),
    .rd_addr (in_tdata[7:0]),
    .rd_data (tbl_word)
  );

  rcdc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .byte_load (byte_load),
    .byte_eos  (in_tlast),
    .tbl_word  (tbl_word),
    .q_room    (q_room),
    .take_ok   (take_ok),
    .push      (push)
  );

  rcdc_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (q_room),
    .head_valid (out_tvalid),
    .head       (head),
    .pop        (out_tready)
  );

  assign out_tdata = {head.len, head.off};
  assign out_tuser = head.run_end;
  assign out_tlast = head.final_chunk;

endmodule

@@ hw/rtl/rcdc_table.sv @@
// ---------------------------------------------------------------------------
// rcdc_table
// 256 x 32 byte table, one write port and one registered read port.
// ---------------------------------------------------------------------------
module rcdc_table
  import rcdc_pkg::*;
(
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [TBL_ADDR_BITS-1:0] wr_addr,
  input  logic [HASH_BITS-1:0]     wr_data,
  input  logic                     rd_en,
  input  logic [TBL_ADDR_BITS-1:0] rd_addr,
  output logic [HASH_BITS-1:0]     rd_data
);

  logic [HASH_BITS-1:0] mem [2**TBL_ADDR_BITS];
  logic [HASH_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Writes and reads come from distinct words, so a read never meets a
  // write to the same entry in one cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/rcdc_core.sv @@
// ---------------------------------------------------------------------------
// rcdc_core
// Configuration registers, running hash and chunk boundary decision.
// ---------------------------------------------------------------------------
module rcdc_core
  import rcdc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     byte_load,
  input  logic                     byte_eos,
  input  logic [HASH_BITS-1:0]     tbl_word,
  input  logic                     q_room,
  output logic                     take_ok,
  output res_push_t                push
);

  logic [HASH_BITS-1:0]   mult_r, mask_r;
  logic [LENGTH_BITS-1:0] min_r, max_r;

  logic                   s1_valid_r, s1_valid_nxt;
  logic                   s1_eos_r;
  logic [HASH_BITS-1:0]   hash_r, hash_nxt;
  logic [LENGTH_BITS-1:0] fill_r, fill_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;

  logic                   fire, cut;
  logic [HASH_BITS-1:0]   prod;
  logic [OFFSET_BITS-1:0] cut_start;
  logic [LENGTH_BITS-1:0] fill_inc;
  chunk_res_t             cut_res, eos_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= '0;
      mask_r <= HASH_BITS'(8191);
      min_r  <= LENGTH_BITS'(2048);
      max_r  <= LENGTH_BITS'(65536);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_HASH_MULT: mult_r <= cfg_wdata;
        REG_HASH_MASK: mask_r <= cfg_wdata;
        REG_MIN_CHUNK: min_r  <= cfg_wdata[LENGTH_BITS-1:0];
        REG_MAX_CHUNK: max_r  <= cfg_wdata[LENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign fire    = s1_valid_r && q_room;
  assign take_ok = !s1_valid_r || fire;

  // The check looks at the hash before the arriving byte is folded in.
  always_comb begin
    cut = 1'b0;
    if (fill_r != '0) begin
      if (fill_r >= max_r) begin
        cut = 1'b1;
      end else if (fill_r >= min_r && (hash_r & mask_r) == '0) begin
        cut = 1'b1;
      end
    end
  end

  assign prod      = mult_r * hash_r;
  assign cut_start = start_r + OFFSET_BITS'(fill_r);
  assign fill_inc  = cut ? LENGTH_BITS'(1) : fill_r + LENGTH_BITS'(1);

  always_comb begin
    cut_res.off         = start_r;
    cut_res.len         = fill_r;
    cut_res.final_chunk = 1'b0;
    cut_res.run_end     = !s1_eos_r;
    eos_res.off         = cut ? cut_start : start_r;
    eos_res.len         = fill_inc;
    eos_res.final_chunk = 1'b1;
    eos_res.run_end     = 1'b1;
  end

  always_comb begin
    push.cnt = '0;
    push.e0  = cut ? cut_res : eos_res;
    push.e1  = eos_res;
    if (fire) begin
      push.cnt = 2'(cut) + 2'(s1_eos_r);
    end
  end

  always_comb begin
    hash_nxt     = hash_r;
    fill_nxt     = fill_r;
    start_nxt    = start_r;
    s1_valid_nxt = s1_valid_r;
    if (fire) begin
      s1_valid_nxt = 1'b0;
      if (s1_eos_r) begin
        hash_nxt  = '0;
        fill_nxt  = '0;
        start_nxt = '0;
      end else begin
        hash_nxt  = (cut ? '0 : prod) + tbl_word;
        fill_nxt  = fill_inc;
        start_nxt = cut ? cut_start : start_r;
      end
    end
    if (byte_load) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      hash_r     <= '0;
      fill_r     <= '0;
      start_r    <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      hash_r     <= hash_nxt;
      fill_r     <= fill_nxt;
      start_r    <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_load) begin
      s1_eos_r <= byte_eos;
    end
  end

endmodule

@@ hw/rtl/rcdc_outq.sv @@
// ---------------------------------------------------------------------------
// rcdc_outq
// Four-entry result queue that takes up to two results per cycle.
// ---------------------------------------------------------------------------
module rcdc_outq
  import rcdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  res_push_t  push,
  output logic       room,
  output logic       head_valid,
  output chunk_res_t head,
  input  logic       pop
);

  chunk_res_t  ent_r [4];
  logic [1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [2:0]  count_r, count_nxt;
  logic        do_pop;

  assign head_valid = count_r != '0;
  assign head       = ent_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;
  // Two free entries are needed for a byte that both cuts and ends the stream.
  assign room       = count_r <= 3'd2;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.cnt;
    rd_ptr_nxt = rd_ptr_r + 2'(do_pop);
    count_nxt  = count_r + 3'(push.cnt) - 3'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      ent_r[wr_ptr_r] <= push.e0;
    end
    if (push.cnt == 2'd2) begin
      ent_r[wr_ptr_r + 2'd1] <= push.e1;
    end
  end

endmodule

@@ hw/rtl/rcdc_checker.sv @@
// ---------------------------------------------------------------------------
// rcdc_checker
// Port-level checks of the chunker, bound to the top level.
// ---------------------------------------------------------------------------
module rcdc_checker
  import rcdc_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tready,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata,
  input logic                     out_tuser,
  input logic                     out_tlast,
  input logic                     cfg_ready
);

  // A stalled word keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // No chunk of length zero is ever emitted.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_BITS-1:OFFSET_BITS] != '0)
    else $error("chunk of length zero");

  // The final chunk, the last result of its byte, always carries run end.
  a_final_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("final chunk without run end");

  // Right after reset nothing is offered and both input sides are ready.
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready && cfg_ready)
    else $error("block not idle after reset");

endmodule

bind rabin_content_defined_chunker rcdc_checker u_rcdc_checker (.*);
